/* design/se2per_pkg.sv */
// Shared widths, constants and types of the planar edge residual pipeline.
package se2per_pkg;

    localparam int POS_W = 32;
    localparam int ANG_W = 31;
    localparam int EA_W = 30;
    localparam int PHI_W = 23;
    localparam int GAIN_W = 16;
    localparam int S_W = 17;
    localparam int CFG_W = PHI_W;
    localparam int CFG_IDX_W = 1;

    localparam int POS_FRAC = 16;
    localparam int ANG_FRAC = 28;
    localparam int ANG_SHIFT = 30 - ANG_FRAC;
    localparam int GUARD = 4;

    localparam int VEC_W = 42;
    localparam int ZW = 36;
    localparam int CORDIC_STEPS = 30;

    localparam int NORM_W = 49;
    localparam int NUM_SHIFT = 25;
    localparam int DEN_SHIFT = 8;
    localparam int NUM_W = PHI_W + NUM_SHIFT;
    localparam int DEN_W = 50;
    localparam int Q_BITS = S_W;

    localparam logic signed [ZW-1:0] PI_Q30 = 36'sd3373259426;
    localparam logic signed [ZW-1:0] TWO_PI_Q30 = 36'sd6746518852;
    localparam logic signed [ZW-1:0] HALF_PI_Q30 = 36'sd1686629713;

    localparam logic signed [15:0] INV_GAIN_HI = 16'sd19898;
    localparam logic signed [15:0] INV_GAIN_LO = 16'sd15210;

    localparam logic [S_W-1:0] S_ONE = 17'd65536;
    localparam logic [NORM_W-1:0] NORM_CAP = 49'h1000000000000;
    localparam logic [PHI_W-1:0] PHI_RESET = 23'd32768;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd2560;

    localparam logic signed [ZW-1:0] ATAN_Q30 [CORDIC_STEPS] = '{
        36'sd843314857, 36'sd497837829, 36'sd263043837, 36'sd133525159, 36'sd67021687,
        36'sd33543516, 36'sd16775851, 36'sd8388437, 36'sd4194283, 36'sd2097149,
        36'sd1048576, 36'sd524288, 36'sd262144, 36'sd131072, 36'sd65536,
        36'sd32768, 36'sd16384, 36'sd8192, 36'sd4096, 36'sd2048,
        36'sd1024, 36'sd512, 36'sd256, 36'sd128, 36'sd64,
        36'sd32, 36'sd16, 36'sd8, 36'sd4, 36'sd2
    };

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PHI  = 1'b0,
        CFG_GAIN = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic                    closure;
        logic signed [POS_W-1:0] mx;
        logic signed [POS_W-1:0] my;
        logic signed [ZW-1:0]    z2;
        logic signed [EA_W-1:0]  ea;
    } rot1_side_t;

    typedef struct packed {
        logic                   closure;
        logic signed [EA_W-1:0] ea;
    } rot2_side_t;

    typedef struct packed {
        logic signed [POS_W-1:0] ex;
        logic signed [POS_W-1:0] ey;
        logic signed [EA_W-1:0]  ea;
    } div_side_t;

endpackage

/* design/se2per_edge_if.sv */
// Request channel that carries one pose-graph edge.
interface se2per_edge_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  scaled_edge;
    logic signed [se2per_pkg::POS_W-1:0]   pose_a_x;
    logic signed [se2per_pkg::POS_W-1:0]   pose_a_y;
    logic signed [se2per_pkg::ANG_W-1:0]   pose_a_angle;
    logic signed [se2per_pkg::POS_W-1:0]   pose_b_x;
    logic signed [se2per_pkg::POS_W-1:0]   pose_b_y;
    logic signed [se2per_pkg::ANG_W-1:0]   pose_b_angle;
    logic signed [se2per_pkg::POS_W-1:0]   meas_dx;
    logic signed [se2per_pkg::POS_W-1:0]   meas_dy;
    logic signed [se2per_pkg::ANG_W-1:0]   meas_dangle;

    modport source (
        output valid, scaled_edge, pose_a_x, pose_a_y, pose_a_angle,
               pose_b_x, pose_b_y, pose_b_angle, meas_dx, meas_dy, meas_dangle,
        input  ready
    );

    modport sink (
        input  valid, scaled_edge, pose_a_x, pose_a_y, pose_a_angle,
               pose_b_x, pose_b_y, pose_b_angle, meas_dx, meas_dy, meas_dangle,
        output ready
    );
endinterface

/* design/se2per_resid_if.sv */
// Request channel that carries one scaled edge residual.
interface se2per_resid_if;
    logic                                valid;
    logic                                ready;
    logic signed [se2per_pkg::POS_W-1:0] err_x;
    logic signed [se2per_pkg::POS_W-1:0] err_y;
    logic signed [se2per_pkg::EA_W-1:0]  err_angle;
    logic [se2per_pkg::PHI_W-1:0]        penalty;
    logic [se2per_pkg::S_W-1:0]          scale_factor;

    modport source (
        output valid, err_x, err_y, err_angle, penalty, scale_factor,
        input  ready
    );

    modport sink (
        input  valid, err_x, err_y, err_angle, penalty, scale_factor,
        output ready
    );
endinterface

/* design/se2_pose_edge_residual_dcs.sv */
// Planar pose-graph edge residual with dynamic covariance scaling, top level.
// Throughput is one edge per cycle; a stalled output freezes every stage in place.
// The depth is set by two 30-step CORDIC rotators and a 17-stage quotient pipeline.
// Reset clears all valid bits and loads phi with 0.5 and the error gain with 10.
module se2_pose_edge_residual_dcs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [se2per_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [se2per_pkg::CFG_W-1:0]     cfg_data,
    se2per_edge_if.sink                      item,
    se2per_resid_if.source                   result
);
    import se2per_pkg::*;

    function automatic logic signed [ZW-1:0] wrap_once(input logic signed [ZW-1:0] z);
        logic signed [ZW-1:0] r;
        r = z;
        if (z > PI_Q30)
            r = z - TWO_PI_Q30;
        else if (z <= -PI_Q30)
            r = z + TWO_PI_Q30;
        return r;
    endfunction

    function automatic logic signed [ZW-1:0] wrap_twice(input logic signed [ZW-1:0] z);
        logic signed [ZW-1:0] r;
        r = z;
        priority if (z > PI_Q30 + TWO_PI_Q30)
            r = z - TWO_PI_Q30 - TWO_PI_Q30;
        else if (z > PI_Q30)
            r = z - TWO_PI_Q30;
        else if (z <= -PI_Q30 - TWO_PI_Q30)
            r = z + TWO_PI_Q30 + TWO_PI_Q30;
        else if (z <= -PI_Q30)
            r = z + TWO_PI_Q30;
        return r;
    endfunction

    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [63:0] v);
        logic signed [POS_W-1:0] r;
        if (v[63:POS_W-1] != {(65-POS_W){v[63]}})
            r = v[63] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
        else
            r = v[POS_W-1:0];
        return r;
    endfunction

    function automatic logic signed [EA_W-1:0] sat_ang(input logic signed [63:0] v);
        logic signed [EA_W-1:0] r;
        if (v[63:EA_W-1] != {(65-EA_W){v[63]}})
            r = v[63] ? {1'b1, {(EA_W-1){1'b0}}} : {1'b0, {(EA_W-1){1'b1}}};
        else
            r = v[EA_W-1:0];
        return r;
    endfunction

    logic [PHI_W-1:0]  phi_reg;
    logic [GAIN_W-1:0] gain_reg;
    logic              adv;

    // Stage one: differences and angles taken to Q30.
    logic                    v_t1_reg;
    logic                    closure_t1_reg;
    logic signed [VEC_W-1:0] vx_t1_reg;
    logic signed [VEC_W-1:0] vy_t1_reg;
    logic signed [ZW-1:0]    naa_t1_reg;
    logic signed [ZW-1:0]    nma_t1_reg;
    logic signed [ZW-1:0]    esum_t1_reg;
    logic signed [POS_W-1:0] mx_t1_reg;
    logic signed [POS_W-1:0] my_t1_reg;
    logic signed [POS_W:0]   dx;
    logic signed [POS_W:0]   dy;
    logic signed [ZW-1:0]    aq;
    logic signed [ZW-1:0]    bq;
    logic signed [ZW-1:0]    mq;

    // Stage two: wrapped angles.
    logic                    v_t2_reg;
    logic                    closure_t2_reg;
    logic signed [VEC_W-1:0] vx_t2_reg;
    logic signed [VEC_W-1:0] vy_t2_reg;
    logic signed [ZW-1:0]    z1_t2_reg;
    logic signed [ZW-1:0]    z2_t2_reg;
    logic signed [ZW-1:0]    ea_t2_reg;
    logic signed [POS_W-1:0] mx_t2_reg;
    logic signed [POS_W-1:0] my_t2_reg;
    logic signed [ZW-1:0]    ea_fold;
    logic signed [EA_W-1:0]  ea_round;

    rot1_side_t              c1_in_side;
    logic                    c1_valid;
    logic signed [VEC_W-1:0] c1_x;
    logic signed [VEC_W-1:0] c1_y;
    logic [$bits(rot1_side_t)-1:0] c1_side_raw;
    rot1_side_t              c1_side;

    logic                    v_t3_reg;
    logic signed [VEC_W-1:0] vx_t3_reg;
    logic signed [VEC_W-1:0] vy_t3_reg;
    logic signed [ZW-1:0]    z2_t3_reg;
    rot2_side_t              side_t3_reg;

    logic                    c2_valid;
    logic signed [VEC_W-1:0] c2_x;
    logic signed [VEC_W-1:0] c2_y;
    logic [$bits(rot2_side_t)-1:0] c2_side_raw;
    rot2_side_t              c2_side;

    logic                    v_t4_reg;
    logic                    closure_t4_reg;
    logic signed [POS_W-1:0] ex_t4_reg;
    logic signed [POS_W-1:0] ey_t4_reg;
    logic signed [EA_W-1:0]  ea_t4_reg;

    logic [POS_W-1:0]        ux;
    logic [POS_W-1:0]        uy;
    logic [EA_W-1:0]         ua;

    logic                    v_t5_reg;
    logic                    closure_t5_reg;
    logic [2*POS_W-1:0]      sqx_t5_reg;
    logic [2*POS_W-1:0]      sqy_t5_reg;
    logic [2*EA_W-1:0]       sqa_t5_reg;
    div_side_t               err_t5_reg;

    logic [NORM_W-1:0]       n_sum;

    logic                    v_t6_reg;
    logic                    closure_t6_reg;
    logic [NORM_W-1:0]       n_t6_reg;
    div_side_t               err_t6_reg;

    logic [GAIN_W+NORM_W-1:0] gprod;

    logic                    v_t7_reg;
    logic                    closure_t7_reg;
    logic [NORM_W-1:0]       x_t7_reg;
    div_side_t               err_t7_reg;

    logic [NUM_W-1:0]        div_num;
    logic [DEN_W-1:0]        div_den;
    logic                    div_bypass;
    logic                    div_valid;
    logic [S_W-1:0]          div_s;
    logic [$bits(div_side_t)-1:0] div_side_raw;
    div_side_t               div_side;

    logic                     v_t8_reg;
    logic [S_W-1:0]           s_t8_reg;
    logic signed [S_W+POS_W:0] px_t8_reg;
    logic signed [S_W+POS_W:0] py_t8_reg;
    logic signed [S_W+EA_W:0]  pa_t8_reg;
    logic [PHI_W+S_W-1:0]     pen_t8_reg;

    logic                    res_valid_reg;
    logic signed [POS_W-1:0] res_ex_reg;
    logic signed [POS_W-1:0] res_ey_reg;
    logic signed [EA_W-1:0]  res_ea_reg;
    logic [PHI_W-1:0]        res_pen_reg;
    logic [S_W-1:0]          res_s_reg;
    logic [PHI_W+S_W:0]      pen_round;

    assign adv        = !res_valid_reg || result.ready;
    assign item.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phi_reg  <= PHI_RESET;
            gain_reg <= GAIN_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_PHI:  phi_reg  <= cfg_data[PHI_W-1:0];
                CFG_GAIN: gain_reg <= cfg_data[GAIN_W-1:0];
                default:  phi_reg  <= phi_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_t1_reg      <= 1'b0;
            v_t2_reg      <= 1'b0;
            v_t3_reg      <= 1'b0;
            v_t4_reg      <= 1'b0;
            v_t5_reg      <= 1'b0;
            v_t6_reg      <= 1'b0;
            v_t7_reg      <= 1'b0;
            v_t8_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v_t1_reg      <= item.valid;
            v_t2_reg      <= v_t1_reg;
            v_t3_reg      <= c1_valid;
            v_t4_reg      <= c2_valid;
            v_t5_reg      <= v_t4_reg;
            v_t6_reg      <= v_t5_reg;
            v_t7_reg      <= v_t6_reg;
            v_t8_reg      <= div_valid;
            res_valid_reg <= v_t8_reg;
        end
    end

    assign dx = {item.pose_b_x[POS_W-1], item.pose_b_x} - {item.pose_a_x[POS_W-1], item.pose_a_x};
    assign dy = {item.pose_b_y[POS_W-1], item.pose_b_y} - {item.pose_a_y[POS_W-1], item.pose_a_y};
    assign aq = ZW'(item.pose_a_angle) <<< ANG_SHIFT;
    assign bq = ZW'(item.pose_b_angle) <<< ANG_SHIFT;
    assign mq = ZW'(item.meas_dangle) <<< ANG_SHIFT;

    // The heading error is folded into a half turn, then rounded half up to the output format.
    always_comb
    begin
        ea_fold = ea_t2_reg;
        if (ea_t2_reg > HALF_PI_Q30)
            ea_fold = PI_Q30 - ea_t2_reg;
        else if (ea_t2_reg < -HALF_PI_Q30)
            ea_fold = -PI_Q30 - ea_t2_reg;
        ea_round = sat_ang((64'(ea_fold) + (64'sd1 <<< (ANG_SHIFT - 1))) >>> ANG_SHIFT);
    end

    assign c1_in_side = '{closure: closure_t2_reg, mx: mx_t2_reg, my: my_t2_reg,
                          z2: z2_t2_reg, ea: ea_round};

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            closure_t1_reg <= item.scaled_edge;
            vx_t1_reg      <= VEC_W'(dx) <<< GUARD;
            vy_t1_reg      <= VEC_W'(dy) <<< GUARD;
            naa_t1_reg     <= -aq;
            nma_t1_reg     <= -mq;
            esum_t1_reg    <= bq - aq - mq;
            mx_t1_reg      <= item.meas_dx;
            my_t1_reg      <= item.meas_dy;

            closure_t2_reg <= closure_t1_reg;
            vx_t2_reg      <= vx_t1_reg;
            vy_t2_reg      <= vy_t1_reg;
            z1_t2_reg      <= wrap_once(naa_t1_reg);
            z2_t2_reg      <= wrap_once(nma_t1_reg);
            ea_t2_reg      <= wrap_twice(esum_t1_reg);
            mx_t2_reg      <= mx_t1_reg;
            my_t2_reg      <= my_t1_reg;
        end
    end

    se2per_cordic #(
        .SIDE_W ($bits(rot1_side_t))
    ) u_rot_a (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (v_t2_reg),
        .in_x      (vx_t2_reg),
        .in_y      (vy_t2_reg),
        .in_z      (z1_t2_reg),
        .in_side   (c1_in_side),
        .out_valid (c1_valid),
        .out_x     (c1_x),
        .out_y     (c1_y),
        .out_side  (c1_side_raw)
    );

    assign c1_side = rot1_side_t'(c1_side_raw);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            vx_t3_reg   <= c1_x - (VEC_W'(c1_side.mx) <<< GUARD);
            vy_t3_reg   <= c1_y - (VEC_W'(c1_side.my) <<< GUARD);
            z2_t3_reg   <= c1_side.z2;
            side_t3_reg <= '{closure: c1_side.closure, ea: c1_side.ea};
        end
    end

    se2per_cordic #(
        .SIDE_W ($bits(rot2_side_t))
    ) u_rot_m (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (v_t3_reg),
        .in_x      (vx_t3_reg),
        .in_y      (vy_t3_reg),
        .in_z      (z2_t3_reg),
        .in_side   (side_t3_reg),
        .out_valid (c2_valid),
        .out_x     (c2_x),
        .out_y     (c2_y),
        .out_side  (c2_side_raw)
    );

    assign c2_side = rot2_side_t'(c2_side_raw);

    assign ux = ex_t4_reg[POS_W-1] ? POS_W'(-ex_t4_reg) : POS_W'(ex_t4_reg);
    assign uy = ey_t4_reg[POS_W-1] ? POS_W'(-ey_t4_reg) : POS_W'(ey_t4_reg);
    assign ua = ea_t4_reg[EA_W-1] ? EA_W'(-ea_t4_reg) : EA_W'(ea_t4_reg);

    assign n_sum = NORM_W'(sqx_t5_reg >> POS_FRAC) + NORM_W'(sqy_t5_reg >> POS_FRAC)
                 + NORM_W'(sqa_t5_reg >> (2 * ANG_FRAC - POS_FRAC));

    assign gprod = (GAIN_W+NORM_W)'(gain_reg) * (GAIN_W+NORM_W)'(n_t6_reg);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            closure_t4_reg <= c2_side.closure;
            ex_t4_reg      <= sat_pos((64'(c2_x) + (64'sd1 <<< (GUARD - 1))) >>> GUARD);
            ey_t4_reg      <= sat_pos((64'(c2_y) + (64'sd1 <<< (GUARD - 1))) >>> GUARD);
            ea_t4_reg      <= c2_side.ea;

            closure_t5_reg <= closure_t4_reg;
            sqx_t5_reg     <= ux * ux;
            sqy_t5_reg     <= uy * uy;
            sqa_t5_reg     <= ua * ua;
            err_t5_reg     <= '{ex: ex_t4_reg, ey: ey_t4_reg, ea: ea_t4_reg};

            closure_t6_reg <= closure_t5_reg;
            n_t6_reg       <= (n_sum > NORM_CAP) ? NORM_CAP : n_sum;
            err_t6_reg     <= err_t5_reg;

            closure_t7_reg <= closure_t6_reg;
            x_t7_reg       <= (gprod > (GAIN_W+NORM_W)'(NORM_CAP)) ? NORM_CAP
                                                                   : gprod[NORM_W-1:0];
            err_t7_reg     <= err_t6_reg;
        end
    end

    // Odometry edges and a zero weighted norm both give a factor of exactly one.
    assign div_num    = {phi_reg, {NUM_SHIFT{1'b0}}};
    assign div_den    = DEN_W'({phi_reg, {DEN_SHIFT{1'b0}}}) + DEN_W'(x_t7_reg);
    assign div_bypass = !closure_t7_reg || (x_t7_reg == '0);

    se2per_div #(
        .SIDE_W ($bits(div_side_t))
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (v_t7_reg),
        .in_num    (div_num),
        .in_den    (div_den),
        .in_bypass (div_bypass),
        .in_side   (err_t7_reg),
        .out_valid (div_valid),
        .out_s     (div_s),
        .out_side  (div_side_raw)
    );

    assign div_side  = div_side_t'(div_side_raw);
    assign pen_round = (PHI_W+S_W+1)'(pen_t8_reg) + (PHI_W+S_W+1)'(32768);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s_t8_reg   <= div_s;
            px_t8_reg  <= $signed({1'b0, div_s}) * div_side.ex;
            py_t8_reg  <= $signed({1'b0, div_s}) * div_side.ey;
            pa_t8_reg  <= $signed({1'b0, div_s}) * div_side.ea;
            pen_t8_reg <= phi_reg * (S_ONE - div_s);

            res_ex_reg  <= sat_pos((64'(px_t8_reg) + 64'sd32768) >>> 16);
            res_ey_reg  <= sat_pos((64'(py_t8_reg) + 64'sd32768) >>> 16);
            res_ea_reg  <= sat_ang((64'(pa_t8_reg) + 64'sd32768) >>> 16);
            res_pen_reg <= PHI_W'(pen_round >> 16);
            res_s_reg   <= s_t8_reg;
        end
    end

    assign result.valid        = res_valid_reg;
    assign result.err_x        = res_ex_reg;
    assign result.err_y        = res_ey_reg;
    assign result.err_angle    = res_ea_reg;
    assign result.penalty      = res_pen_reg;
    assign result.scale_factor = res_s_reg;
endmodule

/* design/se2per_cordic.sv */
// Pipelined CORDIC rotator with quadrant fold and gain removal, one stage per step.
module se2per_cordic #(
    parameter int SIDE_W = 1
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  logic                                in_valid,
    input  logic signed [se2per_pkg::VEC_W-1:0] in_x,
    input  logic signed [se2per_pkg::VEC_W-1:0] in_y,
    input  logic signed [se2per_pkg::ZW-1:0]    in_z,
    input  logic [SIDE_W-1:0]                   in_side,
    output logic                                out_valid,
    output logic signed [se2per_pkg::VEC_W-1:0] out_x,
    output logic signed [se2per_pkg::VEC_W-1:0] out_y,
    output logic [SIDE_W-1:0]                   out_side
);
    import se2per_pkg::*;

    localparam int MUL_W = VEC_W + 16;

    logic                    valid_reg [CORDIC_STEPS+1];
    logic signed [VEC_W-1:0] x_reg [CORDIC_STEPS+1];
    logic signed [VEC_W-1:0] y_reg [CORDIC_STEPS+1];
    logic signed [ZW-1:0]    z_reg [CORDIC_STEPS];
    logic [SIDE_W-1:0]       side_reg [CORDIC_STEPS+1];

    logic signed [VEC_W-1:0] fold_x;
    logic signed [VEC_W-1:0] fold_y;
    logic signed [ZW-1:0]    fold_z;

    logic                    mul_valid_reg;
    logic signed [MUL_W-1:0] hx_reg;
    logic signed [MUL_W-1:0] lx_reg;
    logic signed [MUL_W-1:0] hy_reg;
    logic signed [MUL_W-1:0] ly_reg;
    logic [SIDE_W-1:0]       mul_side_reg;

    logic signed [MUL_W-1:0] tx;
    logic signed [MUL_W-1:0] ty;

    logic                    fin_valid_reg;
    logic signed [VEC_W-1:0] fin_x_reg;
    logic signed [VEC_W-1:0] fin_y_reg;
    logic [SIDE_W-1:0]       fin_side_reg;

    // Angles beyond a quarter turn are moved by half a turn and the vector negated.
    always_comb
    begin
        fold_x = in_x;
        fold_y = in_y;
        fold_z = in_z;
        if (in_z > HALF_PI_Q30)
        begin
            fold_z = in_z - PI_Q30;
            fold_x = -in_x;
            fold_y = -in_y;
        end
        else if (in_z < -HALF_PI_Q30)
        begin
            fold_z = in_z + PI_Q30;
            fold_x = -in_x;
            fold_y = -in_y;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg[0] <= 1'b0;
        else if (en)
            valid_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]    <= fold_x;
            y_reg[0]    <= fold_y;
            z_reg[0]    <= fold_z;
            side_reg[0] <= in_side;
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_step
        logic signed [VEC_W-1:0] sx;
        logic signed [VEC_W-1:0] sy;
        logic                    neg;

        assign sx  = x_reg[i] >>> i;
        assign sy  = y_reg[i] >>> i;
        assign neg = z_reg[i][ZW-1];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[i+1] <= 1'b0;
            else if (en)
                valid_reg[i+1] <= valid_reg[i];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[i+1]    <= neg ? x_reg[i] + sy : x_reg[i] - sy;
                y_reg[i+1]    <= neg ? y_reg[i] - sx : y_reg[i] + sx;
                side_reg[i+1] <= side_reg[i];
            end
        end

        if (i < CORDIC_STEPS - 1)
        begin : g_angle
            always_ff @(posedge clk)
            begin
                if (en)
                    z_reg[i+1] <= neg ? z_reg[i] + ATAN_Q30[i] : z_reg[i] - ATAN_Q30[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg <= 1'b0;
            fin_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            mul_valid_reg <= valid_reg[CORDIC_STEPS];
            fin_valid_reg <= mul_valid_reg;
        end
    end

    // The inverse gain is split into a high and a low half to keep each product narrow.
    assign tx = hx_reg + (lx_reg >>> 15);
    assign ty = hy_reg + (ly_reg >>> 15);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hx_reg       <= MUL_W'(x_reg[CORDIC_STEPS]) * MUL_W'(INV_GAIN_HI);
            lx_reg       <= MUL_W'(x_reg[CORDIC_STEPS]) * MUL_W'(INV_GAIN_LO);
            hy_reg       <= MUL_W'(y_reg[CORDIC_STEPS]) * MUL_W'(INV_GAIN_HI);
            ly_reg       <= MUL_W'(y_reg[CORDIC_STEPS]) * MUL_W'(INV_GAIN_LO);
            mul_side_reg <= side_reg[CORDIC_STEPS];
            fin_x_reg    <= VEC_W'(tx >>> 15);
            fin_y_reg    <= VEC_W'(ty >>> 15);
            fin_side_reg <= mul_side_reg;
        end
    end

    assign out_valid = fin_valid_reg;
    assign out_x     = fin_x_reg;
    assign out_y     = fin_y_reg;
    assign out_side  = fin_side_reg;
endmodule

/* design/se2per_div.sv */
// Pipelined restoring divider that yields the scale factor, one quotient bit per stage.
module se2per_div #(
    parameter int SIDE_W = 1
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic [se2per_pkg::NUM_W-1:0]      in_num,
    input  logic [se2per_pkg::DEN_W-1:0]      in_den,
    input  logic                              in_bypass,
    input  logic [SIDE_W-1:0]                 in_side,
    output logic                              out_valid,
    output logic [se2per_pkg::S_W-1:0]        out_s,
    output logic [SIDE_W-1:0]                 out_side
);
    import se2per_pkg::*;

    localparam int CMP_W = DEN_W + Q_BITS;

    logic              valid_reg [Q_BITS+1];
    logic [NUM_W-1:0]  rem_reg [Q_BITS];
    logic [DEN_W-1:0]  den_reg [Q_BITS];
    logic [Q_BITS-1:0] q_reg [Q_BITS+1];
    logic              byp_reg [Q_BITS+1];
    logic [SIDE_W-1:0] side_reg [Q_BITS+1];

    logic              s_valid_reg;
    logic [S_W-1:0]    s_reg;
    logic [SIDE_W-1:0] s_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg[0] <= 1'b0;
        else if (en)
            valid_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= in_num;
            den_reg[0]  <= in_den;
            q_reg[0]    <= '0;
            byp_reg[0]  <= in_bypass;
            side_reg[0] <= in_side;
        end
    end

    for (genvar k = 0; k < Q_BITS; k++)
    begin : g_bit
        logic [CMP_W-1:0] trial;
        logic [CMP_W-1:0] rem_w;
        logic             take;

        assign trial = CMP_W'(den_reg[k]) << (Q_BITS - 1 - k);
        assign rem_w = CMP_W'(rem_reg[k]);
        assign take  = rem_w >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[k+1] <= 1'b0;
            else if (en)
                valid_reg[k+1] <= valid_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                q_reg[k+1]    <= q_reg[k] | (Q_BITS'(take) << (Q_BITS - 1 - k));
                byp_reg[k+1]  <= byp_reg[k];
                side_reg[k+1] <= side_reg[k];
            end
        end

        if (k < Q_BITS - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k+1] <= take ? NUM_W'(rem_w - trial) : rem_reg[k];
                    den_reg[k+1] <= den_reg[k];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s_valid_reg <= 1'b0;
        else if (en)
            s_valid_reg <= valid_reg[Q_BITS];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (byp_reg[Q_BITS] || q_reg[Q_BITS] > S_ONE)
                s_reg <= S_ONE;
            else
                s_reg <= q_reg[Q_BITS];
            s_side_reg <= side_reg[Q_BITS];
        end
    end

    assign out_valid = s_valid_reg;
    assign out_s     = s_reg;
    assign out_side  = s_side_reg;
endmodule

/* test/testbench.sv */
// Testbench for the planar edge residual block: directed table and random edges,
// checked against stored table results or an in-bench fixed-point model, under random flow control.
`timescale 1ns / 100ps

module testbench;
    import se2per_pkg::*;

    typedef struct packed {
        logic                    scaled_edge;
        logic signed [POS_W-1:0] ax;
        logic signed [POS_W-1:0] ay;
        logic signed [ANG_W-1:0] aa;
        logic signed [POS_W-1:0] bx;
        logic signed [POS_W-1:0] by;
        logic signed [ANG_W-1:0] ba;
        logic signed [POS_W-1:0] mx;
        logic signed [POS_W-1:0] my;
        logic signed [ANG_W-1:0] ma;
    } pose_edge_t;

    typedef struct packed {
        logic signed [POS_W-1:0] err_x;
        logic signed [POS_W-1:0] err_y;
        logic signed [EA_W-1:0]  err_angle;
        logic [PHI_W-1:0]        penalty;
        logic [S_W-1:0]          scale;
    } residual_t;

    typedef struct packed {
        pose_edge_t e;
        logic       known;
        residual_t  r;
    } table_row_t;

    typedef struct {
        longint x;
        longint y;
    } vec2_t;

    localparam int  N_ROWS = 12;
    localparam int  N_PHASES = 6;
    localparam int  PHASE_ITEMS = 330;
    localparam int  DRAIN_CYCLES = 120;
    localparam int  LONG_HOLD = 300;
    localparam real LIMIT_NS = 4000000.0;
    localparam residual_t ZERO_RESULT = '{0, 0, 0, 0, S_ONE};

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;

    se2per_edge_if  req_ch ();
    se2per_resid_if res_ch ();

    se2_pose_edge_residual_dcs dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (req_ch),
        .result    (res_ch)
    );

    residual_t residual_queue [$];
    logic [PHI_W-1:0]  phi_shadow;
    logic [GAIN_W-1:0] gain_shadow;
    int  error_count;
    int  result_count;
    int  edges_sent;
    int  partial_scale_count;
    int  closure_count;
    bit  calm;
    bit  hold_request;

    table_row_t directed_rows [N_ROWS] = '{
        '{'{1'b0, 0, 0, 0, 0, 0, 0, 0, 0, 0}, 1'b1, ZERO_RESULT},
        '{'{1'b1, 0, 0, 0, 0, 0, 0, 0, 0, 0}, 1'b1, ZERO_RESULT},
        '{'{1'b0, 0, 0, 0, 0, 0, 31'sd843314857, 0, 0, 0}, 1'b1, ZERO_RESULT},
        '{'{1'b1, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 31'sd843314857, 32'sh80000000,
            32'sh80000000, -31'sd843314857, 32'sh7FFFFFFF, 32'sh80000000,
            31'sd843314857}, 1'b0, ZERO_RESULT},
        '{'{1'b0, 32'sh80000000, 32'sh80000000, 0, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
            0, 32'sh80000000, 32'sh7FFFFFFF, 0}, 1'b0, ZERO_RESULT},
        '{'{1'b1, 0, 0, 31'sh3FFFFFFF, 32'sd65536, 0, 31'sh40000000, 0, 0,
            31'sh3FFFFFFF}, 1'b0, ZERO_RESULT},
        '{'{1'b0, 0, 0, 31'sh40000000, 32'sd65536, 32'sd65536, 31'sh3FFFFFFF,
            32'sd65536, 0, 31'sh40000000}, 1'b0, ZERO_RESULT},
        '{'{1'b1, 32'sd65536, 0, 0, 32'sd131072, 0, 31'sd421657428, 0, 0, 0},
            1'b0, ZERO_RESULT},
        '{'{1'b1, 0, 0, -31'sd421657428, 0, 32'sd32768, 31'sd421657428, 0,
            32'sd16384, -31'sd421657428}, 1'b0, ZERO_RESULT},
        '{'{1'b0, -32'sd1000, 32'sd5000, 31'sd1, 32'sd7000, -32'sd900, -31'sd1,
            32'sd100, -32'sd100, 31'sd2}, 1'b0, ZERO_RESULT},
        '{'{1'b1, 0, 0, 0, 32'sd10, 32'sd10, 31'sd100, 32'sd10, 32'sd10, 0},
            1'b0, ZERO_RESULT},
        '{'{1'b1, 32'sh55555555, 32'shAAAAAAAA, 31'sh2AAAAAAA, 32'shAAAAAAAA,
            32'sh55555555, 31'sh55555555, 32'sh0F0F0F0F, 32'shF0F0F0F0,
            31'sh1234567}, 1'b0, ZERO_RESULT}
    };

    always #4 clk = ~clk;

    initial
    begin
        #(LIMIT_NS);
        $display("simulation failed");
        $finish;
    end

    function automatic longint saturate(longint v, int w);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (w - 1)) - 1;
        lo = -hi - 1;
        if (v > hi)
            return hi;
        if (v < lo)
            return lo;
        return v;
    endfunction

    function automatic longint wrap_q30(longint a);
        longint r;
        r = a % longint'(TWO_PI_Q30);
        if (r > longint'(PI_Q30))
            r -= longint'(TWO_PI_Q30);
        if (r <= -longint'(PI_Q30))
            r += longint'(TWO_PI_Q30);
        return r;
    endfunction

    function automatic longint strip_gain(longint v);
        longint t;
        t = v * longint'(INV_GAIN_HI) + ((v * longint'(INV_GAIN_LO)) >>> 15);
        return t >>> 15;
    endfunction

    function automatic vec2_t cordic_rotate(vec2_t v, longint z);
        vec2_t w;
        longint sx;
        longint sy;
        w = v;
        z = wrap_q30(z);
        if (z > longint'(HALF_PI_Q30))
        begin
            z -= longint'(PI_Q30);
            w.x = -w.x;
            w.y = -w.y;
        end
        else if (z < -longint'(HALF_PI_Q30))
        begin
            z += longint'(PI_Q30);
            w.x = -w.x;
            w.y = -w.y;
        end
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            sx = w.x >>> i;
            sy = w.y >>> i;
            if (z >= 0)
            begin
                w.x -= sy;
                w.y += sx;
                z -= longint'(ATAN_Q30[i]);
            end
            else
            begin
                w.x += sy;
                w.y -= sx;
                z += longint'(ATAN_Q30[i]);
            end
        end
        w.x = strip_gain(w.x);
        w.y = strip_gain(w.y);
        return w;
    endfunction

    function automatic residual_t predict_residual(pose_edge_t e);
        residual_t r;
        vec2_t v;
        longint aa;
        longint ba;
        longint ma;
        longint ex;
        longint ey;
        longint ea;
        longint s;
        logic [127:0] n;
        logic [127:0] p;
        logic [127:0] den;
        logic [127:0] q;
        logic [127:0] ux;
        logic [127:0] uy;
        logic [127:0] ua;
        aa = longint'($signed(e.aa)) * 4;
        ba = longint'($signed(e.ba)) * 4;
        ma = longint'($signed(e.ma)) * 4;
        v.x = (longint'($signed(e.bx)) - longint'($signed(e.ax))) * 16;
        v.y = (longint'($signed(e.by)) - longint'($signed(e.ay))) * 16;
        v = cordic_rotate(v, -aa);
        v.x -= longint'($signed(e.mx)) * 16;
        v.y -= longint'($signed(e.my)) * 16;
        v = cordic_rotate(v, -ma);
        ex = saturate((v.x + 8) >>> 4, 32);
        ey = saturate((v.y + 8) >>> 4, 32);
        ea = wrap_q30(ba - aa - ma);
        if (ea > longint'(HALF_PI_Q30))
            ea = longint'(PI_Q30) - ea;
        else if (ea < -longint'(HALF_PI_Q30))
            ea = -longint'(PI_Q30) - ea;
        ea = saturate((ea + 2) >>> 2, 30);
        s = 65536;
        r.penalty = '0;
        if (e.scaled_edge)
        begin
            ux = 128'(ex < 0 ? -ex : ex);
            uy = 128'(ey < 0 ? -ey : ey);
            ua = 128'(ea < 0 ? -ea : ea);
            n = ((ux * ux) >> 16) + ((uy * uy) >> 16) + ((ua * ua) >> 40);
            if (n > 128'(NORM_CAP))
                n = 128'(NORM_CAP);
            p = 128'(gain_shadow) * n;
            if (p > 128'(NORM_CAP))
                p = 128'(NORM_CAP);
            den = (128'(phi_shadow) << 8) + p;
            if (den != 0)
            begin
                q = (128'(phi_shadow) << 25) / den;
                s = (q > 65536) ? 65536 : longint'(q);
            end
            r.penalty = PHI_W'((128'(phi_shadow) * 128'(65536 - s) + 32768) >> 16);
            ex = saturate((s * ex + 32768) >>> 16, 32);
            ey = saturate((s * ey + 32768) >>> 16, 32);
            ea = saturate((s * ea + 32768) >>> 16, 30);
        end
        r.err_x = POS_W'(ex);
        r.err_y = POS_W'(ey);
        r.err_angle = EA_W'(ea);
        r.scale = S_W'(s);
        return r;
    endfunction

    task automatic report_mismatch(string field, longint got, longint want);
        error_count++;
        $display("result %0d: %s is %0h, expected %0h", result_count, field, got, want);
    endtask

    always @(posedge clk)
    begin
        residual_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (residual_queue.size() == 0)
            begin
                error_count++;
                $display("result %0d arrived with no edge outstanding", result_count);
            end
            else
            begin
                want = residual_queue.pop_front();
                if (res_ch.err_x !== want.err_x)
                    report_mismatch("err_x", res_ch.err_x, want.err_x);
                if (res_ch.err_y !== want.err_y)
                    report_mismatch("err_y", res_ch.err_y, want.err_y);
                if (res_ch.err_angle !== want.err_angle)
                    report_mismatch("err_angle", res_ch.err_angle, want.err_angle);
                if (res_ch.penalty !== want.penalty)
                    report_mismatch("penalty", res_ch.penalty, want.penalty);
                if (res_ch.scale_factor !== want.scale)
                    report_mismatch("scale_factor", res_ch.scale_factor, want.scale);
                if (want.scale != 0 && want.scale != S_ONE)
                    partial_scale_count++;
            end
            result_count++;
        end
    end

    initial
    begin
        int stall_left;
        stall_left = 0;
        res_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 0;
                stall_left = LONG_HOLD;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                res_ch.ready <= 1'b0;
            end
            else if (!calm && (($urandom % 8) == 0) && ((edges_sent / 256) % 3 != 1))
            begin
                stall_left = $urandom_range(0, 6);
                res_ch.ready <= 1'b0;
            end
            else
                res_ch.ready <= 1'b1;
        end
    end

    task automatic send_edge(pose_edge_t e, bit known, residual_t typed);
        @(negedge clk);
        if (!calm && (($urandom % 6) == 0) && ((edges_sent / 256) % 3 != 2))
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.scaled_edge <= e.scaled_edge;
        req_ch.pose_a_x <= e.ax;
        req_ch.pose_a_y <= e.ay;
        req_ch.pose_a_angle <= e.aa;
        req_ch.pose_b_x <= e.bx;
        req_ch.pose_b_y <= e.by;
        req_ch.pose_b_angle <= e.ba;
        req_ch.meas_dx <= e.mx;
        req_ch.meas_dy <= e.my;
        req_ch.meas_dangle <= e.ma;
        do
            @(posedge clk);
        while (!req_ch.ready);
        residual_queue.insert(residual_queue.size(), known ? typed : predict_residual(e));
        edges_sent++;
        if (e.scaled_edge)
            closure_count++;
    endtask

    task automatic drain_pipeline();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (residual_queue.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(cfg_index_t idx, logic [CFG_W-1:0] value);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        if (idx == CFG_PHI)
            phi_shadow = value[PHI_W-1:0];
        else
            gain_shadow = value[GAIN_W-1:0];
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic signed [ANG_W-1:0] random_angle(int mode);
        int span;
        if (mode == 0)
            return ANG_W'($urandom);
        if (mode == 1)
            return ANG_W'($urandom_range(0, 2 * 843314857) - 843314857);
        span = 1 << $urandom_range(4, 26);
        return ANG_W'(int'($urandom_range(0, 2 * span)) - span);
    endfunction

    function automatic pose_edge_t random_edge();
        pose_edge_t e;
        int kind;
        int span;
        int amode;
        kind = $urandom_range(0, 9);
        amode = (kind < 2) ? 0 : ((kind < 5) ? 1 : 2);
        e.scaled_edge = ($urandom % 4) != 0;
        e.aa = random_angle(amode);
        e.ba = random_angle(amode);
        e.ma = random_angle(amode);
        if (kind < 3)
        begin
            e.ax = $urandom;
            e.ay = $urandom;
            e.bx = $urandom;
            e.by = $urandom;
            e.mx = $urandom;
            e.my = $urandom;
        end
        else
        begin
            span = 1 << $urandom_range(2, 22);
            e.ax = $urandom;
            e.ay = $urandom;
            e.bx = e.ax + int'($urandom_range(0, 2 * span)) - span;
            e.by = e.ay + int'($urandom_range(0, 2 * span)) - span;
            e.mx = int'($urandom_range(0, 2 * span)) - span;
            e.my = int'($urandom_range(0, 2 * span)) - span;
            if (kind > 6)
                e.ba = e.aa + e.ma + random_angle(2);
        end
        return e;
    endfunction

    initial
    begin
        logic [CFG_W-1:0] phase_phi [N_PHASES];
        logic [CFG_W-1:0] phase_gain [N_PHASES];
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = CFG_PHI;
        cfg_data = '0;
        req_ch.valid = 1'b0;
        req_ch.scaled_edge = 1'b0;
        req_ch.pose_a_x = '0;
        req_ch.pose_a_y = '0;
        req_ch.pose_a_angle = '0;
        req_ch.pose_b_x = '0;
        req_ch.pose_b_y = '0;
        req_ch.pose_b_angle = '0;
        req_ch.meas_dx = '0;
        req_ch.meas_dy = '0;
        req_ch.meas_dangle = '0;
        phi_shadow = PHI_RESET;
        gain_shadow = GAIN_RESET;
        error_count = 0;
        result_count = 0;
        edges_sent = 0;
        partial_scale_count = 0;
        closure_count = 0;
        calm = 0;
        hold_request = 0;
        phase_phi = '{CFG_W'(PHI_RESET), 0, 4194304, 1, 4194304, 0};
        phase_gain = '{CFG_W'(GAIN_RESET), 0, 65535, 1, 0, 65535};
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < N_ROWS; i++)
            send_edge(directed_rows[i].e, directed_rows[i].known, directed_rows[i].r);
        drain_pipeline();

        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            if (ph > 0)
            begin
                write_register(CFG_PHI, phase_phi[ph]);
                write_register(CFG_GAIN, phase_gain[ph]);
            end
            if (ph == 2)
                hold_request = 1;
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                calm = (ph == N_PHASES - 1) && (k > PHASE_ITEMS - 100);
                send_edge(random_edge(), 1'b0, ZERO_RESULT);
            end
            drain_pipeline();
        end

        $display("Sent %0d edges (%0d closure) over %0d register settings.",
                 edges_sent, closure_count, N_PHASES);
        $display("Checked %0d residuals, %0d with partial scaling.",
                 result_count, partial_scale_count);
        if (error_count == 0 && residual_queue.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
